### rtl/core/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
// No dependencies; imported by every module of the block.
`default_nettype none

package brf_pkg;

    localparam int DEPTH_DEF = 4096;
    localparam int MAX_XFER  = 64;
    localparam int CNT_W     = 13;
    localparam int LEN_W     = 7;
    localparam int CMD_W     = 3;

    localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic strobe;
        logic ok;
        logic last;
        logic sel;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/byte_ring_fifo_bulk.sv
// Circular byte FIFO with all-or-nothing enqueue transfers.
// Each result is registered and appears in the cycle after the cycle that produces it.
// Enqueue, skip, clear and refusals are handled in the idle state; dequeue and peek
// of n bytes return their bytes one byte per cycle through the store's read port.
// Reset clears pointers, counts and transfer state; the store is not cleared.
// Results cannot be stalled by the receiver. Depends on brf_pkg, brf_ctrl, brf_mem.
`default_nettype none

module byte_ring_fifo_bulk
    import brf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [CMD_W-1:0] cmd,
    input  wire logic [7:0]       data_byte,
    input  wire logic [LEN_W-1:0] xfer_len,
    input  wire logic             last_in,
    output logic                  strobe,
    output logic      [7:0]       data_out,
    output logic                  ok,
    output logic                  last_out,
    output logic      [CNT_W-1:0] used_count,
    output logic      [CNT_W-1:0] free_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    res_t          res;

    brf_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .xfer_len   (xfer_len),
        .last_in    (last_in),
        .busy       (busy),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .res        (res),
        .used_count (used_count),
        .free_count (free_count)
    );

    brf_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign strobe   = res.strobe;
    assign ok       = res.ok;
    assign last_out = res.last;
    assign data_out = res.sel ? mem_rdata : 8'd0;

endmodule

`default_nettype wire

### rtl/core/brf_mem.sv
// Byte store: one write port, one read port, registered read data.
// Depends on brf_pkg.
`default_nettype none

module brf_mem
    import brf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/brf_ctrl.sv
// Command sequencer: pointers, counts, transfer state and memory access.
// Depends on brf_pkg.
`default_nettype none

module brf_ctrl
    import brf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CMD_W-1:0] cmd,
    input  wire logic [7:0]       data_byte,
    input  wire logic [LEN_W-1:0] xfer_len,
    input  wire logic             last_in,
    output logic                  busy,
    output logic                  mem_we,
    output logic      [AW-1:0]    mem_waddr,
    output logic      [7:0]       mem_wdata,
    output logic                  mem_re,
    output logic      [AW-1:0]    mem_raddr,
    output res_t                  res,
    output logic      [CNT_W-1:0] used_count,
    output logic      [CNT_W-1:0] free_count
);

    localparam int XW = CW + LEN_W;
    localparam int SW = CW + LEN_W + 1;

    state_t           state_reg, state_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic             pop_reg, pop_next;
    logic             in_xfer_reg, in_xfer_next;
    logic             xfer_ok_reg, xfer_ok_next;
    res_t             res_reg, res_next;

    logic             accept;
    logic [CW-1:0]    free_now;
    logic [XW-1:0]    len_x;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    free_x;
    logic             len_gt_max;
    logic             len_gt_cnt;
    logic             enq_acc;
    logic [SW-1:0]    skip_sum;
    logic [AW-1:0]    rd_inc;
    logic [AW-1:0]    cur_inc;
    logic [CW+CNT_W-1:0] used_ext;
    logic [CW+CNT_W-1:0] free_ext;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        if (i == AW'(DEPTH - 1))
            return '0;
        else
            return i + AW'(1);
    endfunction

    assign accept     = start && (state_reg == ST_IDLE);
    assign free_now   = CW'(DEPTH) - cnt_reg;
    assign len_x      = XW'(xfer_len);
    assign cnt_x      = XW'(cnt_reg);
    assign free_x     = XW'(free_now);
    assign len_gt_max = xfer_len > LEN_W'(MAX_XFER);
    assign len_gt_cnt = len_x > cnt_x;
    assign enq_acc    = in_xfer_reg ? xfer_ok_reg : ((len_x <= free_x) && !len_gt_max);
    assign rd_inc     = wrap_inc(rd_idx_reg);
    assign cur_inc    = wrap_inc(cur_reg);

    always_comb
    begin
        skip_sum = SW'(rd_idx_reg) + SW'(xfer_len);
        if (skip_sum >= SW'(DEPTH))
        begin
            skip_sum = skip_sum - SW'(DEPTH);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_DEQ || cmd == CMD_PEEK) && !len_gt_max
                    && !len_gt_cnt && xfer_len > LEN_W'(1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (rem_reg == LEN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and results.
    always_comb
    begin
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        pop_next     = pop_reg;
        in_xfer_next = in_xfer_reg;
        xfer_ok_next = xfer_ok_reg;
        res_next     = '0;
        mem_we       = 1'b0;
        mem_waddr    = wr_idx_reg;
        mem_wdata    = data_byte;
        mem_re       = 1'b0;
        mem_raddr    = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.strobe = 1'b1;
                    res_next.last   = 1'b1;
                    case (cmd) inside
                        CMD_ENQ:
                        begin
                            if (enq_acc && cnt_reg < CW'(DEPTH))
                            begin
                                mem_we      = 1'b1;
                                wr_idx_next = wrap_inc(wr_idx_reg);
                                cnt_next    = cnt_reg + CW'(1);
                                res_next.ok = 1'b1;
                            end
                            in_xfer_next = !last_in;
                            xfer_ok_next = enq_acc && !last_in;
                        end
                        CMD_DEQ, CMD_PEEK:
                        begin
                            if (!len_gt_max && !len_gt_cnt)
                            begin
                                res_next.ok = 1'b1;
                                if (xfer_len != '0)
                                begin
                                    mem_re        = 1'b1;
                                    mem_raddr     = rd_idx_reg;
                                    res_next.sel  = 1'b1;
                                    res_next.last = (xfer_len == LEN_W'(1));
                                    cur_next      = rd_inc;
                                    rem_next      = xfer_len - LEN_W'(1);
                                    pop_next      = (cmd == CMD_DEQ);
                                    if (cmd == CMD_DEQ)
                                    begin
                                        rd_idx_next = rd_inc;
                                        cnt_next    = cnt_reg - CW'(1);
                                    end
                                end
                            end
                        end
                        CMD_SKIP:
                        begin
                            if (!len_gt_cnt)
                            begin
                                res_next.ok = 1'b1;
                                rd_idx_next = skip_sum[AW-1:0];
                                cnt_next    = cnt_reg - CW'(xfer_len);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            res_next.ok  = 1'b1;
                            rd_idx_next  = '0;
                            wr_idx_next  = '0;
                            cnt_next     = '0;
                            in_xfer_next = 1'b0;
                            xfer_ok_next = 1'b0;
                        end
                        default:
                        begin
                            res_next.ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                mem_re          = 1'b1;
                mem_raddr       = cur_reg;
                cur_next        = cur_inc;
                rem_next        = rem_reg - LEN_W'(1);
                res_next.strobe = 1'b1;
                res_next.ok     = 1'b1;
                res_next.sel    = 1'b1;
                res_next.last   = (rem_reg == LEN_W'(1));
                if (pop_reg)
                begin
                    rd_idx_next = cur_inc;
                    cnt_next    = cnt_reg - CW'(1);
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            cur_reg     <= '0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            pop_reg     <= 1'b0;
            in_xfer_reg <= 1'b0;
            xfer_ok_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            wr_idx_reg  <= wr_idx_next;
            cur_reg     <= cur_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            pop_reg     <= pop_next;
            in_xfer_reg <= in_xfer_next;
            xfer_ok_reg <= xfer_ok_next;
            res_reg     <= res_next;
        end
    end

    assign used_ext   = {{CNT_W{1'b0}}, cnt_reg};
    assign free_ext   = {{CNT_W{1'b0}}, free_now};
    assign used_count = used_ext[CNT_W-1:0];
    assign free_count = free_ext[CNT_W-1:0];
    assign busy       = (state_reg == ST_RUN);
    assign res        = res_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("stored count exceeds depth");

    a_run_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> rem_reg != '0)
        else $error("sequencer running with nothing left");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_reg.strobe)
        else $error("accepted command gave no result");

    a_run_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |=> res_reg.strobe && res_reg.sel)
        else $error("read cycle gave no byte");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && pop_reg |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("dequeue byte did not lower the count");
`endif

endmodule

`default_nettype wire
